// ===== rtl/ptsr_pkg.sv =====
// Package for the per-type sequence reorder block: field widths, result kinds,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package ptsr_pkg;

  localparam int TYPE_W = 4;
  localparam int SEQ_W  = 16;
  localparam int PAY_W  = 16;
  localparam int DATA_W = 40;
  localparam int KIND_W = 3;

  localparam logic OP_RECV  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_REL   = 3'd0,
    KIND_PASS  = 3'd1,
    KIND_LATE  = 3'd2,
    KIND_DROP  = 3'd3,
    KIND_ALLOC = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_WB,
    ST_DRRD,
    ST_DRCHK,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic clr_en;
    logic accept;
    logic eval;
    logic sl_rd;
    logic step;
    logic push;
    logic push_last;
    logic ch_wr;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic drain;
    logic stored;
    logic cnt_full;
    logic rd_full;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/per_type_sequence_reorder.sv =====
// Top level of the per-type sequence reorder block.
// Uses ptsr_pkg, ptsr_ctrl and ptsr_dpath.
`default_nettype none

// Releases sequenced messages in order per message type. After reset the block
// sweeps its slot memory and channel table and accepts no word meanwhile. A word
// that releases nothing from the window is taken and its channel fetched, then
// evaluated, then written back or emitted. A word that releases messages is taken
// and evaluated, then the drain reads the slot memory one entry at a time and emits
// the released messages in turn. A word is taken only while the controller is
// idle, and a result that cannot enter the output register holds the controller.
// Results leave through an output register, so one result may wait on the master
// side while the next word is taken.
module per_type_sequence_reorder
  import ptsr_pkg::*;
#(
  parameter int TYPES        = 16,
  parameter int WINDOW       = 32,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,  // msg_type[3:0], seq[19:4], payload[35:20]
  input  logic              s_axis_tuser,  // op
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,  // out_type[3:0], out_seq[19:4], out_payload[35:20]
  output logic [KIND_W-1:0] m_axis_tuser,  // out_kind
  output logic              m_axis_tlast
);

  cmd_t              cmd;
  status_t           st;
  logic [TYPE_W-1:0] o_type;
  logic [SEQ_W-1:0]  o_seq;
  logic [PAY_W-1:0]  o_pay;

  ptsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  ptsr_dpath #(
    .TYPES        (TYPES),
    .WINDOW       (WINDOW),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .in_op_i     (s_axis_tuser),
    .in_type_i   (s_axis_tdata[3:0]),
    .in_seq_i    (s_axis_tdata[19:4]),
    .in_pay_i    (s_axis_tdata[35:20]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_type_o  (o_type),
    .out_seq_o   (o_seq),
    .out_pay_o   (o_pay),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  // Pack result word
  assign m_axis_tdata = {4'b0, o_pay, o_seq, o_type};

`ifndef SYNTHESIS
  // Taking a word leaves the idle state, so the input is not ready in the cycle after a take
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken twice in a row");

  // Single-result kinds always close their run
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_ALLOC || m_axis_tuser == KIND_PASS ||
                      m_axis_tuser == KIND_DROP) |-> m_axis_tlast)
    else $error("single result without last");

  // Kind code stays within the defined set
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= KIND_ALLOC)
    else $error("undefined result kind");
`endif

endmodule

`default_nettype wire

// ===== rtl/ptsr_ctrl.sv =====
// Controller state machine for the per-type sequence reorder block.
// Uses ptsr_pkg; drives commands to ptsr_dpath and reads its status.
`default_nettype none

module ptsr_ctrl
  import ptsr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (st_i.clr_done) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_EVAL;
      ST_EVAL: begin
        if (st_i.drain) state_d = ST_DRRD;
        else if (st_i.stored) state_d = ST_WB;
        else state_d = ST_FLUSH;
      end
      ST_WB:    state_d = ST_IDLE;
      ST_DRRD:  state_d = st_i.cnt_full ? ST_FLUSH : ST_DRCHK;
      ST_DRCHK: begin
        if (st_i.out_free) state_d = st_i.rd_full ? ST_DRRD : ST_IDLE;
      end
      ST_FLUSH: if (st_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr_en = 1'b1;
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_EVAL:  cmd_o.eval = 1'b1;
      ST_WB:    cmd_o.ch_wr = 1'b1;
      ST_DRRD:  cmd_o.sl_rd = !st_i.cnt_full;
      ST_DRCHK: begin
        if (st_i.out_free) begin
          cmd_o.push      = 1'b1;
          cmd_o.push_last = !st_i.rd_full;
          cmd_o.step      = st_i.rd_full;
          cmd_o.ch_wr     = !st_i.rd_full;
        end
      end
      ST_FLUSH: begin
        if (st_i.out_free) begin
          cmd_o.push      = 1'b1;
          cmd_o.push_last = 1'b1;
          cmd_o.ch_wr     = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/ptsr_dpath.sv =====
// Datapath for the per-type sequence reorder block: channel table, slot memory,
// pending result and output register. Uses ptsr_pkg; driven by ptsr_ctrl.
`default_nettype none

module ptsr_dpath
  import ptsr_pkg::*;
#(
  parameter int TYPES        = 16,
  parameter int WINDOW       = 32,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output status_t           st_o,
  input  logic              in_op_i,
  input  logic [TYPE_W-1:0] in_type_i,
  input  logic [SEQ_W-1:0]  in_seq_i,
  input  logic [PAY_W-1:0]  in_pay_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [TYPE_W-1:0] out_type_o,
  output logic [SEQ_W-1:0]  out_seq_o,
  output logic [PAY_W-1:0]  out_pay_o,
  output logic [KIND_W-1:0] out_kind_o,
  output logic              out_last_o
);

  localparam int CW    = (TYPES > 1) ? $clog2(TYPES) : 1;
  localparam int HW    = $clog2(WINDOW);
  localparam int DEPTH = TYPES * WINDOW;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;
  localparam int NW    = $clog2(WINDOW + 1);
  localparam int CHW   = 1 + SEQ_W + HW;

  // Type to channel map, constant per parameter set
  logic [CW-1:0] type_map [2**TYPE_W];
  for (genvar i = 0; i < 2**TYPE_W; i++) begin : g_map
    localparam int ChMod = i % TYPES;
    assign type_map[i] = CW'(ChMod);
  end

  // Memories
  logic [SW:0]    slot_mem [DEPTH];
  logic [CHW-1:0] ch_mem   [TYPES];

  // Item and working registers
  logic              op_q;
  logic [TYPE_W-1:0] type_q;
  logic [SEQ_W-1:0]  seq_q;
  logic [SW-1:0]     pay_q;
  logic [CW-1:0]     ch_q;
  logic [CHW-1:0]    ch_rd_q;
  logic [SW:0]       sl_rd_q;
  logic              ex_q;
  logic [SEQ_W-1:0]  exp_q;
  logic [HW-1:0]     head_q;
  logic [NW-1:0]     cnt_q;
  logic [AW-1:0]     clr_q;
  logic [SEQ_W-1:0]  pend_seq_q;
  logic [SW-1:0]     pend_pay_q;
  kind_e             pend_kind_q;

  logic              out_valid_q;
  logic [TYPE_W-1:0] out_type_q;
  logic [SEQ_W-1:0]  out_seq_q;
  logic [PAY_W-1:0]  out_pay_q;
  kind_e             out_kind_q;
  logic              out_last_q;

  // Evaluate the fetched channel against the item
  logic              ex_r;
  logic [SEQ_W-1:0]  exp_r;
  logic [HW-1:0]     head_r;
  logic [SEQ_W-1:0]  exp_alloc, exp_e, seq_s, off;
  logic              late, beyond, seqd, drain, stored;
  logic [HW:0]       slot_sum;
  logic [HW-1:0]     slot_n, head_r_inc, head_q_inc;
  logic [AW-1:0]     base;

  assign {ex_r, exp_r, head_r} = ch_rd_q;
  assign exp_alloc = (ex_r ? exp_r : '0) + SEQ_W'(1);
  assign exp_e     = ex_r ? exp_r : SEQ_W'(1);
  assign late      = seq_q < exp_e;
  assign seq_s     = late ? exp_e : seq_q;
  assign off       = seq_s - exp_e;
  assign beyond    = off >= SEQ_W'(WINDOW);
  assign seqd      = (op_q == OP_RECV) && (seq_q != '0);
  assign drain     = seqd && !beyond && (off == '0);
  assign stored    = seqd && !beyond && (off != '0);
  assign slot_sum  = {1'b0, head_r} + {1'b0, off[HW-1:0]};
  assign slot_n    = (slot_sum >= (HW+1)'(WINDOW)) ? HW'(slot_sum - (HW+1)'(WINDOW))
                                                   : slot_sum[HW-1:0];
  assign head_r_inc = (head_r == HW'(WINDOW - 1)) ? '0 : head_r + HW'(1);
  assign head_q_inc = (head_q == HW'(WINDOW - 1)) ? '0 : head_q + HW'(1);
  assign base       = AW'(ch_q * WINDOW);

  // Status
  assign st_o.clr_done = (clr_q == AW'(DEPTH - 1));
  assign st_o.drain    = drain;
  assign st_o.stored   = stored;
  assign st_o.cnt_full = (cnt_q == NW'(WINDOW));
  assign st_o.rd_full  = sl_rd_q[SW];
  assign st_o.out_free = !out_valid_q || out_ready_i;

  // Slot memory ports
  logic          sl_we;
  logic [AW-1:0] sl_wa;
  logic [SW:0]   sl_wd;
  always_comb begin
    sl_we = 1'b0;
    sl_wa = clr_q;
    sl_wd = '0;
    if (cmd_i.clr_en) begin
      sl_we = 1'b1;
    end else if (cmd_i.eval) begin
      sl_we = seqd && !beyond;
      sl_wa = base + AW'(slot_n);
      sl_wd = {!drain, pay_q};
    end else if (cmd_i.step) begin
      sl_we = 1'b1;
      sl_wa = base + AW'(head_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (sl_we) slot_mem[sl_wa] <= sl_wd;
    if (cmd_i.sl_rd) sl_rd_q <= slot_mem[base + AW'(head_q)];
  end

  // Channel table: cleared after reset, read on accept, written back at the end
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en && (clr_q < AW'(TYPES))) begin
      ch_mem[clr_q[CW-1:0]] <= '0;
    end else if (cmd_i.ch_wr) begin
      ch_mem[ch_q] <= {ex_q, exp_q, head_q};
    end
    if (cmd_i.accept) ch_rd_q <= ch_mem[type_map[in_type_i]];
  end

  // Clear sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_en && !st_o.clr_done) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  // Capture item, evaluate and advance the drain
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= in_op_i;
      type_q <= in_type_i;
      seq_q  <= in_seq_i;
      pay_q  <= in_pay_i[SW-1:0];
      ch_q   <= type_map[in_type_i];
    end
    if (cmd_i.eval) begin
      ex_q   <= ex_r;
      exp_q  <= exp_r;
      head_q <= head_r;
      cnt_q  <= NW'(1);
      pend_pay_q <= '0;
      if (op_q == OP_ALLOC) begin
        ex_q        <= 1'b1;
        exp_q       <= exp_alloc;
        pend_seq_q  <= exp_alloc;
        pend_kind_q <= KIND_ALLOC;
      end else if (!seqd) begin
        pend_seq_q  <= '0;
        pend_pay_q  <= pay_q;
        pend_kind_q <= KIND_PASS;
      end else begin
        ex_q        <= 1'b1;
        exp_q       <= exp_e;
        pend_seq_q  <= seq_s;
        pend_kind_q <= KIND_DROP;
        if (drain) begin
          exp_q       <= exp_e + SEQ_W'(1);
          head_q      <= head_r_inc;
          pend_seq_q  <= exp_e;
          pend_pay_q  <= pay_q;
          pend_kind_q <= late ? KIND_LATE : KIND_REL;
        end
      end
    end else if (cmd_i.step) begin
      pend_seq_q  <= exp_q;
      pend_pay_q  <= sl_rd_q[SW-1:0];
      pend_kind_q <= KIND_REL;
      exp_q       <= exp_q + SEQ_W'(1);
      head_q      <= head_q_inc;
      cnt_q       <= cnt_q + NW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_type_q <= type_q;
      out_seq_q  <= pend_seq_q;
      out_pay_q  <= PAY_W'(pend_pay_q);
      out_kind_q <= pend_kind_q;
      out_last_q <= cmd_i.push_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_type_o  = out_type_q;
  assign out_seq_o   = out_seq_q;
  assign out_pay_o   = out_pay_q;
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire
